FILE: sv/pu_pkg.sv
`default_nettype none

package pu_pkg;

   localparam int MAX_LENGTH = 8;

   localparam int RANK_W  = 16;
   localparam int LEN_W   = 4;
   localparam int POS_W   = 3;
   localparam int VAL_W   = 3;
   localparam int N_W     = $clog2(MAX_LENGTH + 1);
   localparam int PICK_W  = $clog2(MAX_LENGTH);
   localparam int REM_W   = $clog2(2 * MAX_LENGTH);
   localparam int RECIP_W = RANK_W + 1;
   localparam int PROD_W  = RANK_W + RECIP_W;
   localparam int STEP_W  = 2;
   localparam int ROM_DEPTH = 4;

   localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(8);

   typedef logic [RECIP_W-1:0]    recip_type;
   typedef logic [MAX_LENGTH-1:0] mask_type;
   typedef logic [STEP_W-1:0]     step_type;

   // floor(2^16 / n), covers every radix the length range allows
   localparam recip_type RECIP_TABLE [16] = '{
      RECIP_W'(0),     RECIP_W'(65536), RECIP_W'(32768), RECIP_W'(21845),
      RECIP_W'(16384), RECIP_W'(13107), RECIP_W'(10922), RECIP_W'(9362),
      RECIP_W'(8192),  RECIP_W'(7281),  RECIP_W'(6553),  RECIP_W'(5957),
      RECIP_W'(5461),  RECIP_W'(0),     RECIP_W'(0),     RECIP_W'(0)
   };

   typedef enum logic [1:0] {
      WAIT_NONE = 2'd0,
      WAIT_REQ  = 2'd1,
      WAIT_SLOT = 2'd2
   } wait_type;

   typedef enum logic [1:0] {
      BR_NONE  = 2'd0,
      BR_EMPTY = 2'd1,
      BR_MORE  = 2'd2
   } branch_type;

   localparam step_type STEP_LOAD = 2'd0;
   localparam step_type STEP_MUL  = 2'd1;
   localparam step_type STEP_DIV  = 2'd2;
   localparam step_type STEP_EMIT = 2'd3;

   typedef struct packed {
      wait_type   wait_sel;
      logic       do_load;
      logic       do_mul;
      logic       do_div;
      logic       do_emit;
      branch_type br_sel;
      step_type   br_target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic slot_free;
      logic empty;
      logic more;
   } seq_status_type;

   typedef struct packed {
      logic wait_req;
      logic load;
      logic mul;
      logic div;
      logic emit;
   } seq_ctrl_type;

   // one control word per step; a step that waits holds until go, then a taken branch goes to br_target, else next step
   localparam ctrl_word_type MICROCODE [ROM_DEPTH] = '{
      '{WAIT_REQ,  1'b1, 1'b0, 1'b0, 1'b0, BR_EMPTY, STEP_LOAD},
      '{WAIT_NONE, 1'b0, 1'b1, 1'b0, 1'b0, BR_NONE,  STEP_LOAD},
      '{WAIT_NONE, 1'b0, 1'b0, 1'b1, 1'b0, BR_NONE,  STEP_LOAD},
      '{WAIT_SLOT, 1'b0, 1'b0, 1'b0, 1'b1, BR_MORE,  STEP_MUL}
   };

endpackage

`default_nettype wire

FILE: sv/pu_seq.sv
`default_nettype none

module pu_seq
   import pu_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output seq_ctrl_type        ctrl
);

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type word;
   logic          go;
   logic          taken;

   assign word = MICROCODE[step_ff];

   always_comb begin
      unique case (word.wait_sel)
         WAIT_NONE: go = 1'b1;
         WAIT_REQ:  go = status.req_valid;
         WAIT_SLOT: go = status.slot_free;
         default:   go = 1'b1;
      endcase
   end

   always_comb begin
      unique case (word.br_sel)
         BR_NONE:  taken = 1'b0;
         BR_EMPTY: taken = status.empty;
         BR_MORE:  taken = status.more;
         default:  taken = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (go) begin
         step_in = taken ? word.br_target : step_type'(step_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.wait_req = (word.wait_sel == WAIT_REQ);
   assign ctrl.load     = word.do_load & go;
   assign ctrl.mul      = word.do_mul & go;
   assign ctrl.div      = word.do_div & go;
   assign ctrl.emit     = word.do_emit & go;

endmodule

`default_nettype wire

FILE: sv/permutation_unrank_unit.sv
// the first result beat is registered in the emit step, after the load, multiply and correct steps
// each slot runs the multiply, correct and emit steps in the microcode sequencer
// an item of length L occupies the unit for the load step and L passes through the slot steps
// a zero length item is taken and dropped in the load step; stalls on rsp_ hold the emit step
// reset (synchronous, active high) returns to the load step, drops any pending
// result beat and sets perm_length to 8
`default_nettype none

module permutation_unrank_unit
   import pu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               csr_wr_en,
   input  wire logic [LEN_W-1:0]   csr_wr_data,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [RANK_W-1:0]  req_rank,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [POS_W-1:0]        rsp_position,
   output logic [VAL_W-1:0]        rsp_value,
   output logic                    rsp_last
);

   // configuration
   logic [LEN_W-1:0] perm_length_ff;
   logic [N_W-1:0]   len_eff;

   // datapath registers
   logic [RANK_W-1:0] rest_ff,  rest_in;
   logic [N_W-1:0]    n_ff,     n_in;
   logic [N_W-1:0]    digit_ff, digit_in;
   mask_type          used_ff,  used_in;
   logic [PROD_W-1:0] prod_ff,  prod_in;

   // result beat register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_position_ff, rsp_position_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;

   seq_status_type status;
   seq_ctrl_type   ctrl;

   logic [RANK_W-1:0] q_est;
   logic [RANK_W-1:0] qn;
   logic [RANK_W-1:0] rem_wide;
   logic [REM_W-1:0]  rem;
   logic [PICK_W-1:0] pick;
   logic              slot_free;

   // clamp the length to what the unit was built for
   assign len_eff = (perm_length_ff > LEN_W'(MAX_LENGTH)) ? N_W'(MAX_LENGTH)
                                                          : N_W'(perm_length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_length_ff <= RESET_LENGTH;
      end else if (csr_wr_en) begin
         perm_length_ff <= csr_wr_data;
      end
   end

   // sequencer
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign status.req_valid = req_valid;
   assign status.slot_free = slot_free;
   assign status.empty     = (len_eff == '0);
   assign status.more      = (n_ff != N_W'(1));

   pu_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_stall = !ctrl.wait_req;

   // divide by radix: reciprocal estimate is exact or one low
   assign q_est    = prod_ff[2*RANK_W-1:RANK_W];
   assign qn       = RANK_W'(q_est * RANK_W'(n_ff));
   assign rem_wide = rest_ff - qn;
   assign rem      = REM_W'(rem_wide);

   // digit-th free value, counting up from zero
   always_comb begin
      logic [N_W-1:0] cnt;
      logic           found;
      cnt   = digit_ff;
      found = 1'b0;
      pick  = '0;
      for (int v = 0; v < MAX_LENGTH; v++) begin
         if (!found && !used_ff[v]) begin
            if (cnt == '0) begin
               pick  = PICK_W'(v);
               found = 1'b1;
            end else begin
               cnt = cnt - 1'b1;
            end
         end
      end
   end

   always_comb begin
      rest_in  = rest_ff;
      n_in     = n_ff;
      digit_in = digit_ff;
      used_in  = used_ff;
      prod_in  = prod_ff;
      if (ctrl.load) begin
         rest_in = req_rank;
         n_in    = len_eff;
         used_in = '0;
      end
      if (ctrl.mul) begin
         prod_in = PROD_W'(PROD_W'(rest_ff) * PROD_W'(RECIP_TABLE[4'(n_ff)]));
      end
      if (ctrl.div) begin
         // correction: remainder may be one radix too large
         if (rem >= REM_W'(n_ff)) begin
            rest_in  = q_est + 1'b1;
            digit_in = N_W'(rem - REM_W'(n_ff));
         end else begin
            rest_in  = q_est;
            digit_in = N_W'(rem);
         end
      end
      if (ctrl.emit) begin
         used_in = used_ff | (mask_type'(1) << pick);
         n_in    = n_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff  <= rest_in;
      n_ff     <= n_in;
      digit_ff <= digit_in;
      used_ff  <= used_in;
      prod_ff  <= prod_in;
   end

   // output register: next beat loads when the register is empty or as the current one leaves
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_position_in = rsp_position_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_position_in = POS_W'(n_ff - 1'b1);
         rsp_value_in    = VAL_W'(pick);
         rsp_last_in     = (n_ff == N_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_position_ff <= rsp_position_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;

   // digit after correction is always below the radix
   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (digit_ff < n_ff))
      else $error("digit not below radix at emit");

   // the selected value must still be free
   a_pick_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !used_ff[pick])
      else $error("picked value already used");

   a_emit_radix: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (n_ff != '0))
      else $error("emit with zero radix");

   a_last_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_position_ff == '0))
      else $error("last beat not for slot zero");

   // a non-empty item keeps the unit busy on the next cycle
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (len_eff != '0)) |=> req_stall)
      else $error("input taken while an item is in flight");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
   import pu_pkg::*;

   // cycles with no beat on either channel before the run is abandoned
   localparam int IDLE_LIMIT  = 2000;
   // wait longer than an item of length 8 keeps the unit busy, leaving some margin
   localparam int DRAIN_SLACK = 30;
   localparam int PHASE_ITEMS = 32;
   localparam int ZERO_ITEMS  = 8;
   localparam int PHASES      = 14;

   // one result beat: the slot and the element placed in it
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic             last;
   } slot_beat_type;

   typedef enum logic {ROW_PREDICT, ROW_TYPED} row_kind_type;

   // values holds one hex digit per beat, first beat on the left
   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [RANK_W-1:0] rank;
      row_kind_type      kind;
      logic [3:0]        nbeats;
      logic [31:0]       values;
   } directed_row_type;

   localparam int DIR_ROWS = 22;
   localparam directed_row_type DIRECTED [DIR_ROWS] = '{
      // reset length, lowest and highest rank of 8!
      '{4'd8,  16'd0,      ROW_TYPED,   4'd8, 32'h01234567},
      '{4'd8,  16'd40319,  ROW_TYPED,   4'd8, 32'h76543210},
      // one full wrap lands back on the identity
      '{4'd8,  16'd40320,  ROW_TYPED,   4'd8, 32'h01234567},
      '{4'd8,  16'd65535,  ROW_PREDICT, 4'd0, 32'h0},
      '{4'd8,  16'd1,      ROW_PREDICT, 4'd0, 32'h0},
      '{4'd8,  16'haaaa,   ROW_PREDICT, 4'd0, 32'h0},
      '{4'd8,  16'h5555,   ROW_PREDICT, 4'd0, 32'h0},
      // single element, any rank gives one beat
      '{4'd1,  16'd0,      ROW_TYPED,   4'd1, 32'h0},
      '{4'd1,  16'd65535,  ROW_TYPED,   4'd1, 32'h0},
      // zero length, the item is taken and nothing comes back
      '{4'd0,  16'd0,      ROW_TYPED,   4'd0, 32'h0},
      '{4'd0,  16'd65535,  ROW_TYPED,   4'd0, 32'h0},
      // length above the maximum acts as the maximum
      '{4'd15, 16'd0,      ROW_TYPED,   4'd8, 32'h01234567},
      '{4'd15, 16'd40319,  ROW_TYPED,   4'd8, 32'h76543210},
      '{4'd15, 16'd65535,  ROW_PREDICT, 4'd0, 32'h0},
      '{4'd9,  16'd777,    ROW_PREDICT, 4'd0, 32'h0},
      // two elements
      '{4'd2,  16'd0,      ROW_TYPED,   4'd2, 32'h01},
      '{4'd2,  16'd1,      ROW_TYPED,   4'd2, 32'h10},
      '{4'd2,  16'd65535,  ROW_TYPED,   4'd2, 32'h10},
      // three elements, top rank and first wrap
      '{4'd3,  16'd5,      ROW_TYPED,   4'd3, 32'h210},
      '{4'd3,  16'd6,      ROW_TYPED,   4'd3, 32'h012},
      '{4'd3,  16'd3,      ROW_PREDICT, 4'd0, 32'h0},
      '{4'd3,  16'd4,      ROW_PREDICT, 4'd0, 32'h0}
   };

   // length sweep for the random phases, the rest pick a length at random
   localparam logic [LEN_W-1:0] SWEEP [12] = '{
      4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd12, 4'd7, 4'd3, 4'd6, 4'd4, 4'd8
   };

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [LEN_W-1:0]  csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic [RANK_W-1:0] req_rank;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [POS_W-1:0]  rsp_position;
   logic [VAL_W-1:0]  rsp_value;
   logic              rsp_last;

   // our copy of the length register
   logic [LEN_W-1:0]  model_len;
   // slots still owed by the unit, oldest first
   slot_beat_type     pending_slots [$];
   int                mismatches;
   int                idle_cycles;
   bit                no_idle;

   permutation_unrank_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rank     (req_rank),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_position (rsp_position),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none while no_idle is set
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // mostly uniform ranks, some small ones and some around the wrap points
   function automatic logic [RANK_W-1:0] pick_rank();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return RANK_W'($urandom_range(0, 65535));
      if (r < 88) return RANK_W'($urandom_range(0, 5039));
      case ($urandom_range(0, 5))
         0: return RANK_W'(0);
         1: return RANK_W'(65535);
         2: return RANK_W'(40319);
         3: return RANK_W'(40320);
         4: return RANK_W'(5039);
         default: return RANK_W'(5040);
      endcase
   endfunction

   // mixed-radix decode: radix len first, each digit picks among free values
   function automatic void predict_slots(input logic [RANK_W-1:0] rank);
      int            rest;
      int            len;
      int            digit;
      int            pick;
      logic [MAX_LENGTH-1:0] taken;
      slot_beat_type beat;
      rest  = rank;
      len   = (model_len > MAX_LENGTH) ? MAX_LENGTH : model_len;
      taken = '0;
      for (int n = len; n >= 1; n--) begin
         digit = rest % n;
         rest  = rest / n;
         pick  = 0;
         // digit-th free value, counting from the smallest
         for (int v = 0; v < len; v++) begin
            if (!taken[v]) begin
               if (digit == 0) begin
                  pick = v;
                  break;
               end
               digit--;
            end
         end
         taken[pick]   = 1'b1;
         beat.position = POS_W'(n - 1);
         beat.value    = VAL_W'(pick);
         beat.last     = (n == 1);
         pending_slots.push_back(beat);
      end
   endfunction

   // hand-written expectation: slots count down, last on slot zero
   function automatic void push_typed(input directed_row_type row);
      slot_beat_type beat;
      for (int i = 0; i < row.nbeats; i++) begin
         beat.position = POS_W'(row.nbeats - 1 - i);
         beat.value    = row.values[4 * (row.nbeats - 1 - i) +: VAL_W];
         beat.last     = (i == row.nbeats - 1);
         pending_slots.push_back(beat);
      end
   endfunction

   // one request beat, after a random gap; returns at the accepting edge
   task automatic send_rank(input logic [RANK_W-1:0] rank);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rank  <= rank;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // the register only changes with the unit idle: drain, let any dropped
   // zero length item clear, then write
   task automatic set_length(input logic [LEN_W-1:0] len);
      req_valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_len    = len;
   endtask

   // result side stalls in random bursts
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = gap_len();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // every accepted result beat is matched against the oldest owed slot
   always @(posedge clock) begin
      slot_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_slots.size() == 0) begin
            $error("unexpected result beat: position %0d value %0d last %0d",
                   rsp_position, rsp_value, rsp_last);
            mismatches++;
         end else begin
            want = pending_slots.pop_front();
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               mismatches++;
            end
            if (rsp_value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_value);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles where no beat moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [LEN_W-1:0] phase_len;
      int               count;
      clock       = 1'b0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_rank    = '0;
      rsp_stall   = 1'b0;
      model_len   = RESET_LENGTH;
      mismatches  = 0;
      idle_cycles = 0;
      no_idle     = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, the first ones run on the reset length
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].length != model_len) set_length(DIRECTED[i].length);
         send_rank(DIRECTED[i].rank);
         if (DIRECTED[i].kind == ROW_TYPED) push_typed(DIRECTED[i]);
         else predict_slots(DIRECTED[i].rank);
      end

      // random phases, each sets its length first; some with no idling at all
      for (int p = 0; p < PHASES; p++) begin
         phase_len = (p < 12) ? SWEEP[p] : LEN_W'($urandom_range(0, 15));
         set_length(phase_len);
         no_idle = (p % 4 == 2);
         count   = (phase_len == 0) ? ZERO_ITEMS : PHASE_ITEMS;
         for (int i = 0; i < count; i++) begin
            send_rank(pick_rank());
            predict_slots(req_rank);
         end
      end
      no_idle = 1'b0;

      // drain what is still owed, then watch for stray beats
      req_valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);

      if (mismatches == 0 && pending_slots.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
sv/pu_pkg.sv
sv/pu_seq.sv
sv/permutation_unrank_unit.sv
verif/tb_top.sv
